>>> rtl/core/csrmm_pkg.sv
// Shared constants, codes and types of the CSR sparse-by-dense multiply block.
`default_nettype none
package csrmm_pkg;

    // Matrix size and nonzero store capacity
    localparam int DIM    = 16;
    localparam int MAX_NZ = 256;

    // Fixed field widths
    localparam int REQ_W = 2;
    localparam int ROW_W = 4;
    localparam int COL_W = 4;
    localparam int SLOT_W = 8;
    localparam int PTR_W = 9;
    localparam int VAL_W = 16;
    localparam int PROD_W = 2 * VAL_W;
    localparam int SUM_W = 48;
    localparam int ACT_W = 5;

    // Derived widths and constants
    localparam int DIM_AW = $clog2(DIM);
    localparam int NZ_AW = $clog2(MAX_NZ);
    localparam int K_W = $clog2(MAX_NZ + 1);
    localparam int CNT_W = $clog2(DIM + 1);
    localparam int DRAIN_CYC = DIM + 3;
    localparam int DRN_W = $clog2(DRAIN_CYC + 1);
    localparam int ACT_MAX = (1 << ACT_W) - 1;
    localparam int ACT_RESET = (DIM > ACT_MAX) ? ACT_MAX : DIM;

    // Request codes
    typedef enum logic [REQ_W-1:0] {
        REQ_WR_B   = 2'd0,
        REQ_WR_PTR = 2'd1,
        REQ_WR_NZ  = 2'd2,
        REQ_RUN    = 2'd3
    } t_req;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_WALK,
        S_DRAIN,
        S_EMIT
    } t_state;

    // Nonzero token travelling down the cell chain
    typedef struct packed {
        logic                    valid;
        logic [DIM_AW-1:0]       brow;
        logic signed [VAL_W-1:0] val;
    } t_tok;

    // B element write broadcast to the cells
    typedef struct packed {
        logic                    en;
        logic [DIM_AW-1:0]       row;
        logic signed [VAL_W-1:0] val;
    } t_bwr;

    // Accumulator control shared by all cells
    typedef struct packed {
        logic clear;
        logic shift;
    } t_cell_ctl;

endpackage
`default_nettype wire

>>> rtl/core/csr_sparse_dense_matmul.sv
// Top level: CSR sparse row times dense B through a chain of column cells.
//
//  channel | direction | handshake             | words
//  --------+-----------+-----------------------+---------------------------------------
//  in      | to block  | i_in_valid/o_in_stall | load B, load row end, load nonzero, run
//  out     | from blk  | o_out_valid/i_out_stall | one sum per active column, last marked
//  cfg     | to block  | i_cfg_valid/o_cfg_ready | active column count
//
// Load words are taken while the block is idle. A run reads each nonzero of the row
// from the nonzero RAM, waits for the last token to pass the cell chain, then shifts
// out one sum per active column.
// Reset (synchronous) empties all rows and sets the column count to DIM.
// Output stalls hold the output word and pause the column shift-out.
`default_nettype none
module csr_sparse_dense_matmul (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_stall,
    input  wire logic [csrmm_pkg::REQ_W-1:0]         i_req_type,
    input  wire logic [csrmm_pkg::ROW_W-1:0]         i_row_index,
    input  wire logic [csrmm_pkg::COL_W-1:0]         i_col_index,
    input  wire logic [csrmm_pkg::SLOT_W-1:0]        i_slot,
    input  wire logic [csrmm_pkg::PTR_W-1:0]         i_row_end_pointer,
    input  wire logic signed [csrmm_pkg::VAL_W-1:0]  i_value,
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [csrmm_pkg::ACT_W-1:0]         i_cfg_data,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_stall,
    output logic [csrmm_pkg::ROW_W-1:0]              o_out_row,
    output logic [csrmm_pkg::COL_W-1:0]              o_out_col,
    output logic signed [csrmm_pkg::SUM_W-1:0]       o_sum,
    output logic                                     o_last
);
    import csrmm_pkg::*;

    logic                   in_acc, nz_we, bwr_ok;
    logic [NZ_AW-1:0]       nz_raddr;
    logic [COL_W+VAL_W-1:0] nz_rdata;
    logic                   rd_v;
    t_cell_ctl              ctl;
    t_tok                   head_tok;
    t_bwr                   bwr;
    t_tok                   tok   [DIM+1];
    logic signed [SUM_W-1:0] sums [DIM+1];
    t_bwr                   cell_bwr [DIM];
    t_req                   req;

    assign req    = t_req'(i_req_type);
    assign in_acc = i_in_valid && !o_in_stall;

    // Nonzero slot write
    assign nz_we = in_acc && (req == REQ_WR_NZ) && (int'(i_slot) < MAX_NZ);

    csrmm_ram #(
        .WIDTH (COL_W + VAL_W),
        .DEPTH (MAX_NZ)
    ) u_nz_ram (
        .i_clk   (i_clk),
        .i_we    (nz_we),
        .i_waddr (NZ_AW'(i_slot)),
        .i_wdata ({i_col_index, i_value}),
        .i_raddr (nz_raddr),
        .o_rdata (nz_rdata)
    );

    csrmm_ctrl u_ctrl (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_req_type        (i_req_type),
        .i_row_index       (i_row_index),
        .i_row_end_pointer (i_row_end_pointer),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_data        (i_cfg_data),
        .o_nz_raddr        (nz_raddr),
        .o_rd_v            (rd_v),
        .o_ctl             (ctl),
        .i_head_sum        (sums[0]),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_out_row         (o_out_row),
        .o_out_col         (o_out_col),
        .o_sum             (o_sum),
        .o_last            (o_last)
    );

    // Form the token from the read nonzero; drop columns outside B
    always_comb begin
        head_tok.valid = rd_v && (int'(nz_rdata[COL_W+VAL_W-1:VAL_W]) < DIM);
        head_tok.brow  = DIM_AW'(nz_rdata[COL_W+VAL_W-1:VAL_W]);
        head_tok.val   = nz_rdata[VAL_W-1:0];
    end

    // B element write, routed to its column's cell
    assign bwr_ok  = (int'(i_row_index) < DIM) && (int'(i_col_index) < DIM);
    assign bwr.en  = in_acc && (req == REQ_WR_B) && bwr_ok;
    assign bwr.row = DIM_AW'(i_row_index);
    assign bwr.val = i_value;

    assign tok[0]    = head_tok;
    assign sums[DIM] = '0;

    // Column cells: tokens move right, sums shift left to the head
    for (genvar g = 0; g < DIM; g++) begin : g_cell
        always_comb begin
            cell_bwr[g]    = bwr;
            cell_bwr[g].en = bwr.en && (int'(i_col_index) == g);
        end

        csrmm_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_tok   (tok[g]),
            .o_tok   (tok[g+1]),
            .i_bwr   (cell_bwr[g]),
            .i_ctl   (ctl),
            .i_sum   (sums[g+1]),
            .o_sum   (sums[g])
        );
    end

endmodule
`default_nettype wire

>>> rtl/core/csrmm_ram.sv
// Generic single-port-write, registered-read RAM.
`default_nettype none
module csrmm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write one word, read one word registered
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

>>> rtl/core/csrmm_cell.sv
// One column cell: holds a column of B and its running sum, forwards the nonzero token.
`default_nettype none
module csrmm_cell (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire csrmm_pkg::t_tok                 i_tok,
    output csrmm_pkg::t_tok                      o_tok,
    input  wire csrmm_pkg::t_bwr                 i_bwr,
    input  wire csrmm_pkg::t_cell_ctl            i_ctl,
    input  wire logic signed [csrmm_pkg::SUM_W-1:0] i_sum,
    output logic signed [csrmm_pkg::SUM_W-1:0]      o_sum
);
    import csrmm_pkg::*;

    logic signed [VAL_W-1:0]  r_b [DIM];
    t_tok                     r_tok;
    logic signed [PROD_W-1:0] r_prod;
    logic                     r_prod_v;
    logic signed [SUM_W-1:0]  r_sum;
    logic signed [PROD_W-1:0] n_prod;

    // Store this column's B elements
    always_ff @(posedge i_clk) begin
        if (i_bwr.en) begin
            r_b[i_bwr.row] <= i_bwr.val;
        end
    end

    // Multiply the token's value by the selected B element
    always_comb begin
        n_prod = i_tok.val * r_b[i_tok.brow];
    end

    // Forward the token and register the product
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.valid <= 1'b0;
            r_prod_v    <= 1'b0;
        end else begin
            r_tok.valid <= i_tok.valid;
            r_prod_v    <= i_tok.valid;
        end
        r_tok.brow <= i_tok.brow;
        r_tok.val  <= i_tok.val;
        r_prod     <= n_prod;
    end

    // Clear at run start, accumulate, or shift toward the chain head
    always_ff @(posedge i_clk) begin
        if (i_ctl.clear) begin
            r_sum <= '0;
        end else if (i_ctl.shift) begin
            r_sum <= i_sum;
        end else if (r_prod_v) begin
            r_sum <= r_sum + {{(SUM_W - PROD_W){r_prod[PROD_W-1]}}, r_prod};
        end
    end

    assign o_tok = r_tok;
    assign o_sum = r_sum;

endmodule
`default_nettype wire

>>> rtl/core/csrmm_ctrl.sv
// Run sequencer: row pointers, nonzero walk, drain wait and output word register.
`default_nettype none
module csrmm_ctrl (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_stall,
    input  wire logic [csrmm_pkg::REQ_W-1:0]         i_req_type,
    input  wire logic [csrmm_pkg::ROW_W-1:0]         i_row_index,
    input  wire logic [csrmm_pkg::PTR_W-1:0]         i_row_end_pointer,
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [csrmm_pkg::ACT_W-1:0]         i_cfg_data,
    output logic [csrmm_pkg::NZ_AW-1:0]              o_nz_raddr,
    output logic                                     o_rd_v,
    output csrmm_pkg::t_cell_ctl                     o_ctl,
    input  wire logic signed [csrmm_pkg::SUM_W-1:0]  i_head_sum,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_stall,
    output logic [csrmm_pkg::ROW_W-1:0]              o_out_row,
    output logic [csrmm_pkg::COL_W-1:0]              o_out_col,
    output logic signed [csrmm_pkg::SUM_W-1:0]       o_sum,
    output logic                                     o_last
);
    import csrmm_pkg::*;

    t_state r_state, n_state;
    logic [K_W-1:0]    r_ends [DIM];
    logic [K_W-1:0]    r_k, r_end;
    logic [DRN_W-1:0]  r_drn;
    logic [DIM_AW-1:0] r_j;
    logic [ROW_W-1:0]  r_row;
    logic [ACT_W-1:0]  r_act;
    logic              r_rd_v;
    logic              r_out_v;
    logic [ROW_W-1:0]  r_out_row;
    logic [COL_W-1:0]  r_out_col;
    logic signed [SUM_W-1:0] r_out_sum;
    logic              r_out_last;

    logic              in_acc, row_ok, run_ok, ptr_we;
    logic              issue, load, drn_done, more, col_last;
    logic [DIM_AW-1:0] rd_addr;
    logic [K_W-1:0]    rd_data, ptr_sat;
    logic [CNT_W-1:0]  ncols;
    t_req              req;

    // Decode the accepted word
    assign req    = t_req'(i_req_type);
    assign in_acc = i_in_valid && !o_in_stall;
    assign row_ok = int'(i_row_index) < DIM;
    assign run_ok = in_acc && (req == REQ_RUN) && row_ok;
    assign ptr_we = in_acc && (req == REQ_WR_PTR) && row_ok;
    assign ptr_sat = (int'(i_row_end_pointer) > MAX_NZ) ? K_W'(MAX_NZ)
                                                        : K_W'(i_row_end_pointer);

    // One pointer read port: previous row while idle, own row afterwards
    assign rd_addr = (r_state == S_IDLE) ? DIM_AW'(ROW_W'(i_row_index - ROW_W'(1)))
                                         : DIM_AW'(r_row);
    assign rd_data = r_ends[rd_addr];

    // Clamp the active column count
    always_comb begin
        if (r_act == '0) begin
            ncols = CNT_W'(1);
        end else if (int'(r_act) > DIM) begin
            ncols = CNT_W'(DIM);
        end else begin
            ncols = CNT_W'(r_act);
        end
    end

    assign more     = r_k < r_end;
    assign drn_done = int'(r_drn) == DRAIN_CYC - 1;
    assign col_last = (CNT_W'(r_j) + CNT_W'(1)) == ncols;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (run_ok) n_state = S_START;
            S_START: n_state = S_WALK;
            S_WALK:  if (!more) n_state = S_DRAIN;
            S_DRAIN: if (drn_done) n_state = S_EMIT;
            S_EMIT:  if (load && col_last) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // State outputs; hold the input off while reset is applied
    always_comb begin
        o_in_stall  = 1'b1;
        issue       = 1'b0;
        load        = 1'b0;
        unique case (r_state)
            S_IDLE:  o_in_stall = !i_rst_n;
            S_START: ;
            S_WALK:  issue = more;
            S_DRAIN: ;
            S_EMIT:  load = !r_out_v || !i_out_stall;
            default: ;
        endcase
        o_ctl.clear = run_ok;
        o_ctl.shift = load;
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_rd_v  <= 1'b0;
            r_out_v <= 1'b0;
            r_act   <= ACT_W'(ACT_RESET);
        end else begin
            r_state <= n_state;
            r_rd_v  <= issue;
            if (load) begin
                r_out_v <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_v <= 1'b0;
            end
            if (i_cfg_valid) begin
                r_act <= i_cfg_data;
            end
        end
    end

    // Row end pointers, cleared to empty rows
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DIM; i++) begin
                r_ends[i] <= '0;
            end
        end else if (ptr_we) begin
            r_ends[DIM_AW'(i_row_index)] <= ptr_sat;
        end
    end

    // Walk, drain and column counters
    always_ff @(posedge i_clk) begin
        if (run_ok) begin
            r_row <= i_row_index;
            r_k   <= (i_row_index == '0) ? '0 : rd_data;
            r_j   <= '0;
        end else if (issue) begin
            r_k <= r_k + K_W'(1);
        end
        if (r_state == S_START) begin
            r_end <= rd_data;
        end
        if (r_state == S_WALK) begin
            r_drn <= '0;
        end else if (r_state == S_DRAIN) begin
            r_drn <= r_drn + DRN_W'(1);
        end
        if (load) begin
            r_j <= r_j + DIM_AW'(1);
        end
    end

    // Output word register
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_row  <= r_row;
            r_out_col  <= COL_W'(r_j);
            r_out_sum  <= i_head_sum;
            r_out_last <= col_last;
        end
    end

    assign o_cfg_ready = i_rst_n;
    assign o_nz_raddr  = r_k[NZ_AW-1:0];
    assign o_rd_v      = r_rd_v;
    assign o_out_valid = r_out_v;
    assign o_out_row   = r_out_row;
    assign o_out_col   = r_out_col;
    assign o_sum       = r_out_sum;
    assign o_last      = r_out_last;

endmodule
`default_nettype wire

>>> sim/csr_sparse_dense_matmul_tb.sv
// Self-checking testbench for the CSR sparse-by-dense row multiply block.
module csr_sparse_dense_matmul_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import csrmm_pkg::*;

    localparam int LONG_HOLD = 400;
    localparam int PTR_TOP   = (1 << PTR_W) - 1;

    // One input word as the block sees it
    typedef struct packed {
        t_req                    kind;
        logic [ROW_W-1:0]        row;
        logic [COL_W-1:0]        col;
        logic [SLOT_W-1:0]       slot;
        logic [PTR_W-1:0]        ptr;
        logic signed [VAL_W-1:0] val;
    } t_in_word;

    // One column sum of C
    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic [SUM_W-1:0] sum;
        logic             last;
    } t_sum_word;

    // Mirror of the block's stores; computes each row of C and holds the sums still due
    class RowSumBoard;
        logic signed [VAL_W-1:0] b_elem [DIM*DIM];
        logic [PTR_W-1:0]        row_end [DIM];
        logic [COL_W-1:0]        nz_col [MAX_NZ];
        logic signed [VAL_W-1:0] nz_val [MAX_NZ];
        logic [ACT_W-1:0]        col_count;
        t_sum_word               due_sums [$];
        int                      mismatches;
        int                      sums_checked;

        function new();
            col_count = ACT_W'(ACT_RESET);
            foreach (b_elem[i]) b_elem[i] = '0;
            foreach (row_end[i]) row_end[i] = '0;
            foreach (nz_col[i]) nz_col[i] = '0;
            foreach (nz_val[i]) nz_val[i] = '0;
            mismatches = 0;
            sums_checked = 0;
        endfunction

        // Column count clamped to 1..DIM
        function int cols_live();
            if (col_count == 0) return 1;
            if (col_count > DIM) return DIM;
            return col_count;
        endfunction

        // Apply one accepted word; a run queues one sum per live column
        function void note_word(t_in_word w);
            longint    acc [DIM];
            int        first;
            int        stop;
            int        ncols;
            t_sum_word s;
            case (w.kind)
                REQ_WR_B: b_elem[w.row * DIM + w.col] = w.val;
                REQ_WR_PTR: row_end[w.row] = (w.ptr > MAX_NZ) ? PTR_W'(MAX_NZ) : w.ptr;
                REQ_WR_NZ: begin
                    nz_col[w.slot] = w.col;
                    nz_val[w.slot] = w.val;
                end
                REQ_RUN: begin
                    ncols = cols_live();
                    first = (w.row == 0) ? 0 : row_end[w.row - 1];
                    stop = row_end[w.row];
                    foreach (acc[j]) acc[j] = 0;
                    // walk the row's slots; an end at or below the start walks nothing
                    for (int k = first; k < stop && k < MAX_NZ; k++)
                        for (int j = 0; j < ncols; j++)
                            acc[j] += longint'(nz_val[k]) * longint'(b_elem[nz_col[k] * DIM + j]);
                    for (int j = 0; j < ncols; j++) begin
                        s.row = w.row;
                        s.col = COL_W'(j);
                        s.sum = acc[j][SUM_W-1:0];
                        s.last = (j == ncols - 1);
                        due_sums.push_back(s);
                    end
                end
            endcase
        endfunction

        // Compare one output word with the oldest sum due
        function void check_sum(t_sum_word got);
            t_sum_word want;
            if (due_sums.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected sum word: row %0d col %0d sum %0d last %0b",
                             got.row, got.col, $signed(got.sum), got.last);
                return;
            end
            want = due_sums.pop_front();
            sums_checked++;
            if (got.row !== want.row || got.col !== want.col ||
                got.sum !== want.sum || got.last !== want.last) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"sum word wrong: expected row %0d col %0d sum %0d last %0b, ",
                              "got row %0d col %0d sum %0d last %0b"},
                             want.row, want.col, $signed(want.sum), want.last,
                             got.row, got.col, $signed(got.sum), got.last);
            end
        endfunction
    endclass

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_in_valid = 1'b0;
    logic                    o_in_stall;
    logic [REQ_W-1:0]        i_req_type = '0;
    logic [ROW_W-1:0]        i_row_index = '0;
    logic [COL_W-1:0]        i_col_index = '0;
    logic [SLOT_W-1:0]       i_slot = '0;
    logic [PTR_W-1:0]        i_row_end_pointer = '0;
    logic signed [VAL_W-1:0] i_value = '0;
    logic                    i_cfg_valid = 1'b0;
    logic                    o_cfg_ready;
    logic [ACT_W-1:0]        i_cfg_data = '0;
    logic                    o_out_valid;
    logic                    i_out_stall = 1'b0;
    logic [ROW_W-1:0]        o_out_row;
    logic [COL_W-1:0]        o_out_col;
    logic signed [SUM_W-1:0] o_sum;
    logic                    o_last;

    RowSumBoard sb = new();

    // Track which store entries hold data so no run reads an unwritten one
    bit b_set [DIM*DIM];
    bit nz_set [MAX_NZ];

    int tx_idle_pct = 0;
    int rx_stall_pct = 0;
    int hold_requests = 0;
    int holds_taken = 0;
    int hold_left = 0;
    int words_sent = 0;
    int runs_sent = 0;
    int cfg_writes = 0;

    always #1 i_clk = ~i_clk;

    csr_sparse_dense_matmul i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_req_type        (i_req_type),
        .i_row_index       (i_row_index),
        .i_col_index       (i_col_index),
        .i_slot            (i_slot),
        .i_row_end_pointer (i_row_end_pointer),
        .i_value           (i_value),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_data        (i_cfg_data),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_out_row         (o_out_row),
        .o_out_col         (o_out_col),
        .o_sum             (o_sum),
        .o_last            (o_last)
    );

    // Take output words and drive stall; a requested long hold is counted here
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_sum(t_sum_word'{o_out_row, o_out_col, o_sum, o_last});
        if (hold_requests != holds_taken) begin
            holds_taken <= hold_requests;
            hold_left <= LONG_HOLD;
            i_out_stall <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= (rx_stall_pct != 0) && ($urandom_range(99) < rx_stall_pct);
        end
    end

    function automatic t_in_word make_word(t_req kind, int row, int col, int slot, int ptr,
                                           logic signed [VAL_W-1:0] val);
        t_in_word w;
        w.kind = kind;
        w.row = ROW_W'(row);
        w.col = COL_W'(col);
        w.slot = SLOT_W'(slot);
        w.ptr = PTR_W'(ptr);
        w.val = val;
        return w;
    endfunction

    // Random contents in every field, including the ones the operation ignores
    function automatic t_in_word random_fill();
        t_in_word w;
        w.kind = t_req'($urandom_range(3));
        w.row = ROW_W'($urandom());
        w.col = COL_W'($urandom());
        w.slot = SLOT_W'($urandom());
        w.ptr = PTR_W'($urandom());
        w.val = VAL_W'($urandom());
        return w;
    endfunction

    function automatic logic signed [VAL_W-1:0] pick_value();
        case ($urandom_range(9))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            default: return VAL_W'($urandom());
        endcase
    endfunction

    // Find the first unwritten entry a run of this row would read; fill names the write
    function automatic bit find_gap(logic [ROW_W-1:0] r, output t_in_word fill);
        int first;
        int stop;
        int nc;
        fill = random_fill();
        first = (r == 0) ? 0 : sb.row_end[r - 1];
        stop = (sb.row_end[r] > MAX_NZ) ? MAX_NZ : sb.row_end[r];
        nc = sb.cols_live();
        for (int k = first; k < stop; k++) begin
            if (!nz_set[k]) begin
                fill.kind = REQ_WR_NZ;
                fill.slot = SLOT_W'(k);
                if ($urandom_range(1) == 0) fill.col = COL_W'($urandom_range(3));
                fill.val = pick_value();
                return 1'b1;
            end
            for (int j = 0; j < nc; j++) begin
                if (!b_set[sb.nz_col[k] * DIM + j]) begin
                    fill.kind = REQ_WR_B;
                    fill.row = sb.nz_col[k];
                    fill.col = COL_W'(j);
                    fill.val = pick_value();
                    return 1'b1;
                end
            end
        end
        return 1'b0;
    endfunction

    // Mostly loads that build short rows over a few B rows, plus runs of ready rows
    function automatic t_in_word random_word();
        t_in_word         w;
        t_in_word         fix;
        t_in_word         spare;
        logic [ROW_W-1:0] r;
        int               pick;
        int               nc;
        w = random_fill();
        pick = $urandom_range(99);
        nc = sb.cols_live();
        if (pick < 28) begin
            w.kind = REQ_WR_B;
            if ($urandom_range(1) == 0) w.row = ROW_W'($urandom_range(3));
            if ($urandom_range(4) != 0) w.col = COL_W'($urandom_range(nc - 1));
            w.val = pick_value();
        end else if (pick < 48) begin
            w.kind = REQ_WR_NZ;
            case ($urandom_range(5))
                0: w.slot = SLOT_W'($urandom_range(MAX_NZ - 1, MAX_NZ - 16));
                1: ;
                default: w.slot = SLOT_W'($urandom_range(47));
            endcase
            if ($urandom_range(1) == 0) w.col = COL_W'($urandom_range(3));
            w.val = pick_value();
        end else if (pick < 60) begin
            w.kind = REQ_WR_PTR;
            case ($urandom_range(9))
                0: w.ptr = PTR_W'($urandom_range(MAX_NZ, MAX_NZ - 16));
                1: w.ptr = PTR_W'($urandom_range(PTR_TOP, MAX_NZ + 1));
                2: ;
                default: w.ptr = PTR_W'($urandom_range(48));
            endcase
        end else begin
            w.kind = REQ_RUN;
            if (!find_gap(w.row, fix)) return w;
            // half the time fill what the chosen row still lacks
            if ($urandom_range(1) == 0) return fix;
            for (int i = 1; i < DIM; i++) begin
                r = w.row + ROW_W'(i);
                if (!find_gap(r, spare)) begin
                    w.row = r;
                    return w;
                end
            end
            return fix;
        end
        return w;
    endfunction

    // Offer one word after a random gap and hold it until accepted
    task automatic send_word(input t_in_word w);
        while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_req_type <= w.kind;
        i_row_index <= w.row;
        i_col_index <= w.col;
        i_slot <= w.slot;
        i_row_end_pointer <= w.ptr;
        i_value <= w.val;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_word(w);
        words_sent++;
        case (w.kind)
            REQ_WR_B: b_set[w.row * DIM + w.col] = 1'b1;
            REQ_WR_NZ: nz_set[w.slot] = 1'b1;
            REQ_RUN: runs_sent++;
            default: ;
        endcase
    endtask

    // Drop valid and wait until every queued sum has come out
    task automatic wait_for_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (sb.due_sums.size() != 0);
    endtask

    // Write the column count once the block has gone quiet
    task automatic write_cols(input logic [ACT_W-1:0] cols);
        wait_for_results();
        repeat (DIM + 12) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= cols;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        sb.col_count = cols;
        cfg_writes++;
    endtask

    task automatic run_phase(input logic [ACT_W-1:0] cols, input int tx_pct, input int rx_pct,
                             input int count, input bit long_hold, input bit drain_mid);
        write_cols(cols);
        tx_idle_pct = tx_pct;
        rx_stall_pct <= rx_pct;
        if (long_hold) hold_requests <= hold_requests + 1;
        for (int n = 0; n < count; n++) begin
            if (drain_mid && n == count / 2) wait_for_results();
            send_word(random_word());
        end
    endtask

    // Give up on a hung run
    initial begin
        #2_000_000;
        $display("csr_sparse_dense_matmul: mismatch");
        $finish;
    end

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // all rows empty after reset, every column live
        send_word(make_word(REQ_RUN, 0, 0, 0, 0, 0));
        write_cols(2);
        // extreme B elements in the first and last rows
        send_word(make_word(REQ_WR_B, 0, 0, 0, 0, 16'sh7FFF));
        send_word(make_word(REQ_WR_B, 0, 1, 0, 0, 16'sh8000));
        send_word(make_word(REQ_WR_B, 15, 0, 0, 0, 16'sh8000));
        send_word(make_word(REQ_WR_B, 15, 1, 0, 0, 16'sh7FFF));
        send_word(make_word(REQ_WR_B, 15, 15, 0, 0, 16'sh0100));
        // nonzeros at both ends of the store
        send_word(make_word(REQ_WR_NZ, 0, 0, 0, 0, 16'sh8000));
        send_word(make_word(REQ_WR_NZ, 0, 15, 1, 0, 16'sh7FFF));
        send_word(make_word(REQ_WR_NZ, 0, 15, MAX_NZ - 1, 0, 16'sh8000));
        send_word(make_word(REQ_WR_NZ, 0, 0, MAX_NZ - 2, 0, 16'sh7FFF));
        // row 0 spans two slots
        send_word(make_word(REQ_WR_PTR, 0, 0, 0, 2, 0));
        send_word(make_word(REQ_RUN, 0, 0, 0, 0, 0));
        // rows whose end sits below their start
        send_word(make_word(REQ_WR_PTR, 1, 0, 0, 1, 0));
        send_word(make_word(REQ_RUN, 1, 0, 0, 0, 0));
        send_word(make_word(REQ_RUN, 2, 0, 0, 0, 0));
        // last row: pointer far above capacity saturates, then at and just above it
        send_word(make_word(REQ_WR_PTR, 14, 0, 0, MAX_NZ - 2, 0));
        send_word(make_word(REQ_WR_PTR, 15, 0, 0, PTR_TOP, 0));
        send_word(make_word(REQ_RUN, 15, 0, 0, 0, 0));
        send_word(make_word(REQ_WR_PTR, 15, 0, 0, MAX_NZ, 0));
        send_word(make_word(REQ_RUN, 15, 0, 0, 0, 0));
        send_word(make_word(REQ_WR_PTR, 15, 0, 0, MAX_NZ + 1, 0));
        send_word(make_word(REQ_RUN, 15, 0, 0, 0, 0));

        // random phases over column counts and handshake pressure
        run_phase(16, 0, 0, 60, 1'b0, 1'b0);
        run_phase(1, 57, 0, 50, 1'b0, 1'b0);
        run_phase(31, 0, 57, 60, 1'b1, 1'b0);
        run_phase(0, 17, 17, 40, 1'b0, 1'b0);
        run_phase(5, 0, 0, 60, 1'b0, 1'b1);
        run_phase(ACT_W'($urandom_range(ACT_MAX)), 17, 17, 60, 1'b0, 1'b0);
        run_phase(16, 0, 57, 60, 1'b0, 1'b0);

        // drain and let the chain settle
        rx_stall_pct <= 0;
        wait_for_results();
        repeat (DIM + 30) @(posedge i_clk);

        $display("%0d input words sent, %0d of them row runs, %0d column sums compared",
                 words_sent, runs_sent, sb.sums_checked);
        $display("%0d column-count settings, long output hold and full drain pause included",
                 cfg_writes);
        if (sb.mismatches == 0) begin
            $display("csr_sparse_dense_matmul: match");
        end else begin
            $display("csr_sparse_dense_matmul: mismatch");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/core/csrmm_pkg.sv
rtl/core/csrmm_ram.sv
rtl/core/csrmm_cell.sv
rtl/core/csrmm_ctrl.sv
rtl/core/csr_sparse_dense_matmul.sv
sim/csr_sparse_dense_matmul_tb.sv
